// ===== hdl/b2d_pkg.sv =====
// b2d_pkg: shared types, constants and helpers for the binary to decimal ascii core
// no dependencies; imported by b2d_dabble, binary_to_decimal_ascii_core and tb
`default_nettype none

package b2d_pkg;

    // ascii codes used on the output
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    // double dabble digit correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;
    localparam logic [3:0] BCD_MAX     = 4'd9;

    // top level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_DIGIT
    } t_state;

    // status of the shift-add-3 unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_dab_stat;

    // add 3 to a bcd digit of 5 or more before the next shift
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        return (d >= BCD_ADJ_MIN) ? (d + BCD_ADJ) : d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/b2d_if.sv =====
// b2d_if: valid/ready channel interfaces for the input number and the output characters
// no dependencies; used by binary_to_decimal_ascii_core and tb
`default_nettype none

interface b2d_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface b2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/b2d_dabble.sv =====
// b2d_dabble: iterative shift-add-3 binary to bcd converter, one bit per cycle
// depends on b2d_pkg
`default_nettype none

module b2d_dabble
    import b2d_pkg::*;
#(
    parameter int W    = 32,
    parameter int NDIG = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W-1:0]      i_mag,
    output t_dab_stat              o_stat,
    output logic [NDIG*4-1:0]      o_bcd
);

    localparam int BW = NDIG * 4;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_bin;
    logic [BW-1:0] r_bcd;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [BW-1:0] w_adj;
    logic          w_digits_ok;

    // add-3 correction on every digit lane
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            w_adj[k*4 +: 4] = bcd_adjust(r_bcd[k*4 +: 4]);
        end
    end

    // every digit stays a legal bcd code
    always_comb begin
        w_digits_ok = 1'b1;
        for (int k = 0; k < NDIG; k++) begin
            if (r_bcd[k*4 +: 4] > BCD_MAX) begin
                w_digits_ok = 1'b0;
            end
        end
    end

    // control: bit counter, busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift binary msb into the corrected bcd word
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[W-2:0], 1'b0};
            r_bcd <= {w_adj[BW-2:0], r_bin[W-1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

    // checks
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while the unit is still busy");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && !r_done))
        else $error("start while a conversion is in flight");

    a_bcd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> w_digits_ok)
        else $error("bcd digit above nine after conversion");

    a_done_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1) && !i_start) |=> r_done)
        else $error("conversion did not finish after the last bit");

endmodule

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_core.sv =====
// binary_to_decimal_ascii_core: top level, sequencer, sign handling and character output
// depends on b2d_pkg, b2d_if and b2d_dabble
//
//   channel  dir  payload                          handshake
//   i_in     in   value[VALUE_WIDTH], is_signed    valid/ready (b2d_in_if.sink)
//   o_out    out  character[8], last               valid/ready (b2d_out_if.source)
//
// an item is accepted in the idle state, then the convert state runs the VALUE_WIDTH
// shift-add-3 steps and waits for the done pulse, a sign state follows for a negative
// number, then the skip state drops leading zeros and the digit state sends one digit
// per cycle while o_out is not stalled; the converter loop dominates.
// i_in.ready is high only while the sequencer is idle; one item at a time.
// a stalled o_out holds the character register and the sequencer waits on it.
// synchronous active-low reset returns to idle with the output register empty.
`default_nettype none

module binary_to_decimal_ascii_core
    import b2d_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b2d_in_if.sink     i_in,
    b2d_out_if.source  o_out
);

    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int IDXW = $clog2(NDIG);

    t_state                 r_state, n_state;
    logic                   r_neg, n_neg;
    logic [IDXW-1:0]        r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic                   w_accept;
    logic                   w_slot_free;
    logic [VALUE_WIDTH-1:0] w_value;
    logic                   w_in_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    t_dab_stat              w_dab;
    logic [NDIG*4-1:0]      w_bcd;
    logic [3:0]             w_digit;

    // input transfer and magnitude
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && (r_state == ST_IDLE);
    assign w_value     = i_in.value;
    assign w_in_neg    = i_in.is_signed && w_value[VALUE_WIDTH-1];
    assign w_mag       = w_in_neg ? (~w_value + 1'b1) : w_value;
    assign w_slot_free = !r_out_valid || o_out.ready;

    b2d_dabble #(
        .W    (VALUE_WIDTH),
        .NDIG (NDIG)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_mag),
        .o_stat  (w_dab),
        .o_bcd   (w_bcd)
    );

    // current digit under the pointer
    assign w_digit = w_bcd[{r_idx, 2'b00} +: 4];

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // sequencer: convert, sign, skip leading zeros, send digits
    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_neg   = w_in_neg;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_idx = IDXW'(NDIG - 1);
                if (w_dab.done) begin
                    n_state = r_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (w_digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHR_ZERO + {4'd0, w_digit};
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CONV && w_dab.busy))
        else $error("accepted item did not start a conversion");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_char == CHR_MINUS) |-> !r_out_last)
        else $error("minus sign flagged as the final character");

    a_conv_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dab.busy |-> r_state == ST_CONV)
        else $error("converter running outside the convert state");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for binary_to_decimal_ascii_core, number in, decimal text out
// depends on b2d_pkg, b2d_if and binary_to_decimal_ascii_core
// numbers go in from a queue, expected characters come from a local predictor
`default_nettype none

module tb
    import b2d_pkg::*;
();

    localparam int VALUE_WIDTH    = 32;
    localparam int RANDOM_NUMBERS = 190;
    localparam int TAIL_NUMBERS   = 30;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 60;
    localparam int STALL_LIMIT    = 3000;

    // one number to convert, optionally held back until all text has drained
    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   is_signed;
        bit                     drain_first;
    } t_number;

    // one expected output character
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_char;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   src_valid  = 1'b0;
    logic [VALUE_WIDTH-1:0] src_value  = '0;
    logic                   src_signed = 1'b0;
    logic                   sink_ready = 1'b0;

    t_number pending_numbers[$];
    t_char   expected_chars[$];

    int total_numbers    = 0;
    int numbers_accepted = 0;
    int chars_predicted  = 0;
    int chars_checked    = 0;
    int text_errors      = 0;

    b2d_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
    b2d_out_if out_ch ();

    assign in_ch.valid     = src_valid;
    assign in_ch.value     = src_value;
    assign in_ch.is_signed = src_signed;
    assign out_ch.ready    = sink_ready;

    binary_to_decimal_ascii_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decimal text of one number, appended to the expected characters
    function automatic int predict_text(input logic [VALUE_WIDTH-1:0] value,
                                        input logic is_signed);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic                   negative;
        int                     digits[$];
        t_char                  ch;
        negative  = is_signed && value[VALUE_WIDTH-1];
        magnitude = negative ? (~value + 1'b1) : value;
        do begin
            digits.push_front(int'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative) begin
            ch.character = CHR_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        foreach (digits[k]) begin
            ch.character = CHR_ZERO + 8'(digits[k]);
            ch.last      = (k == digits.size() - 1);
            expected_chars.push_back(ch);
        end
        return digits.size() + (negative ? 1 : 0);
    endfunction

    function automatic void queue_number(input logic [VALUE_WIDTH-1:0] value,
                                         input logic is_signed, input bit drain_first);
        t_number num;
        num.value       = value;
        num.is_signed   = is_signed;
        num.drain_first = drain_first;
        pending_numbers.push_back(num);
        total_numbers++;
    endfunction

    // idling allowed outside calm stretches and the final part of the run
    function automatic bit idling_allowed();
        return (numbers_accepted % 64 < 48) &&
               (numbers_accepted < total_numbers - TAIL_NUMBERS);
    endfunction

    // stimulus, reset and end of run
    initial begin
        logic [VALUE_WIDTH-1:0] pow10;
        logic [VALUE_WIDTH-1:0] v;
        // directed: zero, single digits, decade edges, width extremes
        queue_number(32'd0, 1'b0, 1'b0);
        queue_number(32'd0, 1'b1, 1'b0);
        queue_number(32'd1, 1'b0, 1'b0);
        queue_number(32'd9, 1'b1, 1'b0);
        queue_number(32'd10, 1'b0, 1'b0);
        queue_number(32'd99, 1'b0, 1'b0);
        queue_number(32'd100, 1'b1, 1'b0);
        queue_number(32'd999999999, 1'b0, 1'b0);
        queue_number(32'd1000000000, 1'b1, 1'b0);
        queue_number(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_number(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_number(32'h8000_0000, 1'b1, 1'b0);
        queue_number(32'h8000_0000, 1'b0, 1'b0);
        queue_number(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_number(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_number(32'hFFFF_FFF6, 1'b1, 1'b0);
        queue_number(32'hFFFF_FFF6, 1'b0, 1'b0);
        queue_number(32'hC465_3600, 1'b1, 1'b0);
        queue_number(32'h5555_5555, 1'b0, 1'b0);
        queue_number(32'hAAAA_AAAA, 1'b1, 1'b1);
        // random: full range, small values, shifted, decade edges, small negatives
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            case ($urandom_range(0, 4))
                0: v = $urandom;
                1: v = $urandom_range(0, 99);
                2: v = $urandom >> $urandom_range(0, 31);
                3: begin
                    pow10 = 1;
                    repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
                    v = pow10 + $urandom_range(0, 2) - 1;
                end
                default: v = 32'd0 - $urandom_range(1, 1000);
            endcase
            queue_number(v, 1'($urandom_range(0, 1)), n == 100);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_accepted != total_numbers || chars_predicted != chars_checked)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (text_errors == 0 && expected_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // number driver
    always @(posedge clk) begin
        bit taken;
        int gap_left;
        int added;
        if (!rst_n) begin
            src_valid <= 1'b0;
            gap_left = 0;
        end else begin
            taken = src_valid && in_ch.ready;
            added = 0;
            if (taken) begin
                added = predict_text(pending_numbers[0].value, pending_numbers[0].is_signed);
                chars_predicted <= chars_predicted + added;
                pending_numbers.pop_front();
                numbers_accepted <= numbers_accepted + 1;
            end
            if (src_valid && !taken) begin
                // keep offering the same number
            end else if (gap_left > 0) begin
                gap_left--;
                src_valid <= 1'b0;
            end else if (pending_numbers.size() == 0) begin
                src_valid <= 1'b0;
            end else if (pending_numbers[0].drain_first &&
                         chars_predicted + added != chars_checked) begin
                src_valid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(0, 3);
                src_valid <= 1'b0;
            end else begin
                src_valid  <= 1'b1;
                src_value  <= pending_numbers[0].value;
                src_signed <= pending_numbers[0].is_signed;
            end
        end
    end

    // character monitor and receiver stalls
    always @(posedge clk) begin
        t_char want;
        int    hold_left;
        bit    long_hold_done;
        if (!rst_n) begin
            sink_ready <= 1'b0;
            hold_left = 0;
            long_hold_done = 0;
        end else begin
            if (out_ch.valid && sink_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character transfer: %h last %b",
                           out_ch.character, out_ch.last);
                    text_errors++;
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked <= chars_checked + 1;
                    if (out_ch.character !== want.character) begin
                        $error("character: expected %h, actual %h",
                               want.character, out_ch.character);
                        text_errors++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, out_ch.last);
                        text_errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                sink_ready <= 1'b0;
            end else if (!long_hold_done && numbers_accepted >= 60) begin
                // long hold-off so the core backs up and blocks its input
                long_hold_done = 1;
                hold_left = LONG_HOLD - 1;
                sink_ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 3);
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        int quiet_cycles;
        if (!rst_n || (src_valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
